### hdl/wfhd_pkg.sv
`timescale 1ns / 1ps
// Package for the window, force and hold detector.
// Field widths, register map, reset values and the saturating absolute value.
// No dependencies.
package wfhd_pkg;

   localparam int TIME_W   = 62;
   localparam int END_W    = 63;
   localparam int VALUE_W  = 32;
   localparam int THRESH_W = 31;
   localparam int DUR_W    = 40;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;

   // Register indexes, at byte address 8 * index.
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_LOW      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_HIGH     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FORCE_THRESHOLD = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_HOLD_NS         = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STRETCH_NS      = 3'd4;

   // Item operation codes.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_POLL   = 1'b1;

   localparam logic signed [VALUE_W-1:0] WINDOW_LOW_RESET  = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] WINDOW_HIGH_RESET = 32'sh7FFF_FFFF;
   localparam logic [THRESH_W-1:0] FORCE_THRESHOLD_RESET   = 31'd65536000;
   localparam logic [DUR_W-1:0]    HOLD_NS_RESET           = 40'd500000000;
   localparam logic [DUR_W-1:0]    STRETCH_NS_RESET        = 40'd1000000000;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [END_W-1:0]  end_type;

   // Absolute effort; the most negative value saturates to the largest magnitude.
   function automatic logic [THRESH_W-1:0] abs_sat(input logic signed [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] neg;
      neg = -v;
      if (v == 32'sh8000_0000) begin
         return {THRESH_W{1'b1}};
      end else if (v < 0) begin
         return neg[THRESH_W-1:0];
      end else begin
         return v[THRESH_W-1:0];
      end
   endfunction

endpackage

### hdl/wfhd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the detector's request and response beats.
// Depends on wfhd_pkg for field widths.
interface wfhd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic [wfhd_pkg::TIME_W-1:0]          time_ns;
   logic signed [wfhd_pkg::VALUE_W-1:0]  position;
   logic signed [wfhd_pkg::VALUE_W-1:0]  effort;

   modport source (output valid, operation, time_ns, position, effort, input ready);
   modport sink   (input valid, operation, time_ns, position, effort, output ready);
endinterface

interface wfhd_rsp_if;
   logic valid;
   logic ready;
   logic grasp;
   logic first_trigger;

   modport source (output valid, grasp, first_trigger, input ready);
   modport sink   (input valid, grasp, first_trigger, output ready);
endinterface

### hdl/window_force_hold_detector_core.sv
`timescale 1ns / 1ps
// A request beat is taken into the input register, and its result beat, if any, is taken
// into the response register when the evaluation stage advances.
// Throughput: one request beat per cycle while the response side is not stalled; the state
// update of one beat is done in the single evaluation stage, so the next beat follows with no gap.
// A stalled response register holds the evaluation stage, which then holds the input.
// Reset (synchronous, active high) clears all detector state and restores register defaults.
module window_force_hold_detector_core (
   input  logic                                 clock,
   input  logic                                 reset,
   wfhd_req_if.sink                             req_bus,
   wfhd_rsp_if.source                           rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [wfhd_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [wfhd_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [wfhd_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   // Configuration registers.
   logic signed [wfhd_pkg::VALUE_W-1:0]  window_low_ff;
   logic signed [wfhd_pkg::VALUE_W-1:0]  window_high_ff;
   logic [wfhd_pkg::THRESH_W-1:0]        force_threshold_ff;
   logic [wfhd_pkg::DUR_W-1:0]           hold_ns_ff;
   logic [wfhd_pkg::DUR_W-1:0]           stretch_ns_ff;

   logic                                 csr_write;
   logic [wfhd_pkg::REG_IDX_W-1:0]       csr_index;

   // Input stage.
   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_op_ff;
   wfhd_pkg::time_type     s1_time_ff;
   logic                   s1_cand_ff, s1_cand_in;

   // Detector state.
   logic                   cand_active_ff, cand_active_in;
   logic                   cand_triggered_ff, cand_triggered_in;
   logic                   sig_active_ff, sig_active_in;
   logic                   have_prev_ff, have_prev_in;
   wfhd_pkg::time_type     cand_start_ff, cand_start_in;
   wfhd_pkg::time_type     prev_time_ff, prev_time_in;
   wfhd_pkg::end_type      sig_end_ff, sig_end_in;

   // Response register.
   logic                   out_valid_ff, out_valid_in;
   logic                   out_grasp_ff, out_grasp_in;
   logic                   out_first_ff, out_first_in;

   logic                   req_accept;
   logic                   advance;
   logic                   went_back;
   logic                   eff_cand_active;
   logic                   eff_cand_triggered;
   logic                   eff_sig_active;
   wfhd_pkg::end_type      eff_sig_end;
   wfhd_pkg::time_type     start_time;
   wfhd_pkg::time_type     elapsed;
   logic                   held;
   logic                   produce;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[wfhd_pkg::CSR_ADDR_W-1:wfhd_pkg::CSR_ADDR_W-wfhd_pkg::REG_IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff      <= wfhd_pkg::WINDOW_LOW_RESET;
         window_high_ff     <= wfhd_pkg::WINDOW_HIGH_RESET;
         force_threshold_ff <= wfhd_pkg::FORCE_THRESHOLD_RESET;
         hold_ns_ff         <= wfhd_pkg::HOLD_NS_RESET;
         stretch_ns_ff      <= wfhd_pkg::STRETCH_NS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            wfhd_pkg::REG_WINDOW_LOW: begin
               window_low_ff <= pwdata[wfhd_pkg::VALUE_W-1:0];
            end
            wfhd_pkg::REG_WINDOW_HIGH: begin
               window_high_ff <= pwdata[wfhd_pkg::VALUE_W-1:0];
            end
            wfhd_pkg::REG_FORCE_THRESHOLD: begin
               force_threshold_ff <= pwdata[wfhd_pkg::THRESH_W-1:0];
            end
            wfhd_pkg::REG_HOLD_NS: begin
               hold_ns_ff <= pwdata[wfhd_pkg::DUR_W-1:0];
            end
            wfhd_pkg::REG_STRETCH_NS: begin
               stretch_ns_ff <= pwdata[wfhd_pkg::DUR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         wfhd_pkg::REG_WINDOW_LOW:
            prdata = {{(wfhd_pkg::CSR_DATA_W-wfhd_pkg::VALUE_W){window_low_ff[wfhd_pkg::VALUE_W-1]}},
                      window_low_ff};
         wfhd_pkg::REG_WINDOW_HIGH:
            prdata = {{(wfhd_pkg::CSR_DATA_W-wfhd_pkg::VALUE_W){window_high_ff[wfhd_pkg::VALUE_W-1]}},
                      window_high_ff};
         wfhd_pkg::REG_FORCE_THRESHOLD:
            prdata = {{(wfhd_pkg::CSR_DATA_W-wfhd_pkg::THRESH_W){1'b0}}, force_threshold_ff};
         wfhd_pkg::REG_HOLD_NS:
            prdata = {{(wfhd_pkg::CSR_DATA_W-wfhd_pkg::DUR_W){1'b0}}, hold_ns_ff};
         wfhd_pkg::REG_STRETCH_NS:
            prdata = {{(wfhd_pkg::CSR_DATA_W-wfhd_pkg::DUR_W){1'b0}}, stretch_ns_ff};
         default:
            prdata = '0;
      endcase
   end

   // ---------------- input stage ----------------
   // The window and force test needs only the beat and the configuration, so it is
   // done on the way into the input register.
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;

   assign s1_cand_in = (req_bus.position >= window_low_ff) &&
                       (req_bus.position <= window_high_ff) &&
                       (wfhd_pkg::abs_sat(req_bus.effort) >= force_threshold_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= req_bus.operation;
         s1_time_ff <= req_bus.time_ns;
         s1_cand_ff <= s1_cand_in;
      end
   end

   // ---------------- evaluation stage ----------------
   // A sample stamped before the previous one starts the detector over.
   assign went_back          = have_prev_ff && (s1_time_ff < prev_time_ff);
   assign eff_cand_active    = cand_active_ff && !went_back;
   assign eff_cand_triggered = cand_triggered_ff && !went_back;
   assign eff_sig_active     = sig_active_ff && !went_back;
   assign eff_sig_end        = went_back ? {1'b0, s1_time_ff} : sig_end_ff;
   assign start_time         = eff_cand_active ? cand_start_ff : s1_time_ff;
   assign elapsed            = s1_time_ff - start_time;
   assign held = (s1_time_ff >= start_time) &&
                 (elapsed >= {{(wfhd_pkg::TIME_W-wfhd_pkg::DUR_W){1'b0}}, hold_ns_ff});

   always_comb begin
      cand_active_in    = cand_active_ff;
      cand_triggered_in = cand_triggered_ff;
      sig_active_in     = sig_active_ff;
      have_prev_in      = have_prev_ff;
      cand_start_in     = cand_start_ff;
      prev_time_in      = prev_time_ff;
      sig_end_in        = sig_end_ff;
      produce           = 1'b0;
      out_grasp_in      = 1'b0;
      out_first_in      = 1'b0;
      if (s1_op_ff == wfhd_pkg::OP_POLL) begin
         produce      = 1'b1;
         out_grasp_in = sig_active_ff && ({1'b0, s1_time_ff} <= sig_end_ff);
      end else begin
         have_prev_in  = 1'b1;
         prev_time_in  = s1_time_ff;
         sig_active_in = eff_sig_active;
         sig_end_in    = eff_sig_end;
         if (!s1_cand_ff) begin
            cand_active_in    = 1'b0;
            cand_triggered_in = 1'b0;
         end else begin
            cand_active_in    = 1'b1;
            cand_start_in     = start_time;
            cand_triggered_in = eff_cand_triggered;
            if (held) begin
               // The end time cannot wrap, so the signal is always live here.
               sig_end_in = {1'b0, s1_time_ff} +
                            {{(wfhd_pkg::END_W-wfhd_pkg::DUR_W){1'b0}}, stretch_ns_ff};
               sig_active_in     = 1'b1;
               cand_triggered_in = 1'b1;
               produce           = 1'b1;
               out_grasp_in      = 1'b1;
               out_first_in      = !eff_cand_triggered;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_active_ff    <= 1'b0;
         cand_triggered_ff <= 1'b0;
         sig_active_ff     <= 1'b0;
         have_prev_ff      <= 1'b0;
         cand_start_ff     <= '0;
         prev_time_ff      <= '0;
         sig_end_ff        <= '0;
      end else if (advance) begin
         cand_active_ff    <= cand_active_in;
         cand_triggered_ff <= cand_triggered_in;
         sig_active_ff     <= sig_active_in;
         have_prev_ff      <= have_prev_in;
         cand_start_ff     <= cand_start_in;
         prev_time_ff      <= prev_time_in;
         sig_end_ff        <= sig_end_in;
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = produce;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         out_grasp_ff <= out_grasp_in;
         out_first_ff <= out_first_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.grasp         = out_grasp_ff;
   assign rsp_bus.first_trigger = out_first_ff;

endmodule

### hdl/wfhd_checker.sv
`timescale 1ns / 1ps
// Port-level checks for window_force_hold_detector_core, attached by bind.
// Depends on the core and on the wfhd_req_if / wfhd_rsp_if interfaces.
module wfhd_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_grasp,
   input logic rsp_first_trigger
);

   // A stalled response beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grasp) && $stable(rsp_first_trigger))
      else $error("response beat changed while stalled");

   // A first detection always reports an asserted grasp signal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_trigger |-> rsp_grasp)
      else $error("first_trigger without grasp");

   // Reset empties the response register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A waiting request beat is held back only by a stalled response beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input held with the response side free");

endmodule

bind window_force_hold_detector_core wfhd_checker u_wfhd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_grasp         (rsp_bus.grasp),
   .rsp_first_trigger (rsp_bus.first_trigger)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the window, force and hold grasp detector core.
// Depends on wfhd_pkg, the wfhd_req_if and wfhd_rsp_if interfaces and the
// window_force_hold_detector_core module.
module testbench;

   localparam wfhd_pkg::time_type BASE_NS = 62'd1000;
   localparam int       QUIET_LIMIT    = 4000;
   localparam int       HOLD_OFF_CYCLES = 400;
   localparam int       DRAIN_CYCLES   = 6;
   localparam int       PHASE_ITEMS    = 200;

   // Predicts the grasp results from its own copy of the registers and state,
   // and checks each response beat against the oldest prediction.
   class grasp_scoreboard;
      typedef struct packed {
         logic grasp;
         logic first_trigger;
      } grasp_result_type;

      logic signed [wfhd_pkg::VALUE_W-1:0] window_lo;
      logic signed [wfhd_pkg::VALUE_W-1:0] window_hi;
      logic [wfhd_pkg::THRESH_W-1:0]       min_effort;
      logic [wfhd_pkg::DUR_W-1:0]          hold_time;
      logic [wfhd_pkg::DUR_W-1:0]          stretch_time;

      bit                 cand_active;
      bit                 cand_triggered;
      bit                 sig_active;
      bit                 have_prev_time;
      wfhd_pkg::time_type cand_start;
      wfhd_pkg::time_type prev_time;
      wfhd_pkg::end_type  sig_end;

      grasp_result_type pending_grasps[$];
      int mismatches;
      int requests_seen;
      int results_checked;
      int polls;
      int detections;
      int rewinds;

      function new();
         window_lo    = wfhd_pkg::WINDOW_LOW_RESET;
         window_hi    = wfhd_pkg::WINDOW_HIGH_RESET;
         min_effort   = wfhd_pkg::FORCE_THRESHOLD_RESET;
         hold_time    = wfhd_pkg::HOLD_NS_RESET;
         stretch_time = wfhd_pkg::STRETCH_NS_RESET;
      endfunction

      function void write_register(input logic [wfhd_pkg::REG_IDX_W-1:0] idx,
                                   input logic [wfhd_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            wfhd_pkg::REG_WINDOW_LOW:      window_lo    = value[wfhd_pkg::VALUE_W-1:0];
            wfhd_pkg::REG_WINDOW_HIGH:     window_hi    = value[wfhd_pkg::VALUE_W-1:0];
            wfhd_pkg::REG_FORCE_THRESHOLD: min_effort   = value[wfhd_pkg::THRESH_W-1:0];
            wfhd_pkg::REG_HOLD_NS:         hold_time    = value[wfhd_pkg::DUR_W-1:0];
            wfhd_pkg::REG_STRETCH_NS:      stretch_time = value[wfhd_pkg::DUR_W-1:0];
            default: ;
         endcase
      endfunction

      function void predict_grasp(input logic op, input wfhd_pkg::time_type t,
                                  input logic signed [wfhd_pkg::VALUE_W-1:0] pos,
                                  input logic signed [wfhd_pkg::VALUE_W-1:0] eff);
         logic [wfhd_pkg::VALUE_W-1:0] magnitude;
         bit candidate;
         bit first;
         requests_seen++;
         if (op == wfhd_pkg::OP_POLL) begin
            polls++;
            pending_grasps.push_back({sig_active && ({1'b0, t} <= sig_end), 1'b0});
            return;
         end
         // A timestamp that runs backward wipes the detector before this sample.
         if (have_prev_time && t < prev_time) begin
            cand_active    = 0;
            cand_triggered = 0;
            sig_active     = 0;
            sig_end        = {1'b0, t};
            rewinds++;
         end
         have_prev_time = 1;
         prev_time      = t;
         magnitude = eff[wfhd_pkg::VALUE_W-1] ? -eff : eff;
         if (eff == 32'sh8000_0000) begin
            magnitude = 32'h7FFF_FFFF;
         end
         candidate = pos >= window_lo && pos <= window_hi && magnitude >= {1'b0, min_effort};
         if (!candidate) begin
            cand_active    = 0;
            cand_triggered = 0;
            return;
         end
         if (!cand_active) begin
            cand_active = 1;
            cand_start  = t;
         end
         if (t < cand_start || (t - cand_start) < hold_time) begin
            return;
         end
         sig_end        = {1'b0, t} + stretch_time;
         sig_active     = 1;
         first          = !cand_triggered;
         cand_triggered = 1;
         detections++;
         pending_grasps.push_back({({1'b0, t} <= sig_end), first});
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         $display("%0t ns: MISMATCH %0s", $realtime, what);
      endtask

      task check_result(input logic grasp, input logic first_trigger);
         grasp_result_type want;
         results_checked++;
         if (pending_grasps.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: grasp=%0b first_trigger=%0b",
                                      grasp, first_trigger));
            return;
         end
         want = pending_grasps.pop_front();
         if (grasp !== want.grasp) begin
            report_mismatch($sformatf("grasp %0b, predicted %0b", grasp, want.grasp));
         end
         if (first_trigger !== want.first_trigger) begin
            report_mismatch($sformatf("first_trigger %0b, predicted %0b",
                                      first_trigger, want.first_trigger));
         end
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [wfhd_pkg::CSR_ADDR_W-1:0] paddr;
   logic [wfhd_pkg::CSR_DATA_W-1:0] pwdata;
   logic [wfhd_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   wfhd_req_if req_bus();
   wfhd_rsp_if rsp_bus();

   grasp_scoreboard sb = new();

   wfhd_pkg::time_type cur_time;
   int       burst_left;
   int       quiet_cycles;
   int       csr_writes;
   int       settings_used;

   window_force_hold_detector_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_item(input logic op, input wfhd_pkg::time_type t,
                            input logic signed [wfhd_pkg::VALUE_W-1:0] pos,
                            input logic signed [wfhd_pkg::VALUE_W-1:0] eff);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 9);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         // Now and then a long burst with no gaps at all.
         burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.time_ns   <= t;
      req_bus.position  <= pos;
      req_bus.effort    <= eff;
      do @(posedge clock); while (!req_bus.ready);
      sb.predict_grasp(op, t, pos, eff);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [wfhd_pkg::REG_IDX_W-1:0] idx,
                            input logic [wfhd_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_register(idx, value);
      csr_writes++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Lets the pipeline empty out, including beats that produce no result.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_grasps.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_setting(input logic signed [wfhd_pkg::VALUE_W-1:0] lo,
                                input logic signed [wfhd_pkg::VALUE_W-1:0] hi,
                                input logic [wfhd_pkg::THRESH_W-1:0] thr,
                                input logic [wfhd_pkg::DUR_W-1:0] hold,
                                input logic [wfhd_pkg::DUR_W-1:0] stretch);
      drain();
      write_csr(wfhd_pkg::REG_WINDOW_LOW, wfhd_pkg::CSR_DATA_W'(lo));
      write_csr(wfhd_pkg::REG_WINDOW_HIGH, wfhd_pkg::CSR_DATA_W'(hi));
      write_csr(wfhd_pkg::REG_FORCE_THRESHOLD, wfhd_pkg::CSR_DATA_W'(thr));
      write_csr(wfhd_pkg::REG_HOLD_NS, wfhd_pkg::CSR_DATA_W'(hold));
      write_csr(wfhd_pkg::REG_STRETCH_NS, wfhd_pkg::CSR_DATA_W'(stretch));
      settings_used++;
   endtask

   task automatic run_directed();
      send_item(wfhd_pkg::OP_POLL,   BASE_NS, 0, 0);
      send_item(wfhd_pkg::OP_SAMPLE, BASE_NS, 0, 32'sh7FFF_FFFF);
      // One nanosecond short of the hold time, extreme position and effort.
      send_item(wfhd_pkg::OP_SAMPLE, BASE_NS + 499999999, 32'sh8000_0000, 32'sh8000_0000);
      // Hold reached exactly, effort exactly at the threshold: first detection.
      send_item(wfhd_pkg::OP_SAMPLE, BASE_NS + 500000000, 32'sh7FFF_FFFF, 32'sd65536000);
      send_item(wfhd_pkg::OP_SAMPLE, BASE_NS + 600000000, 0, -32'sd65536000);
      send_item(wfhd_pkg::OP_POLL,   BASE_NS + 1600000000, 0, 0);
      send_item(wfhd_pkg::OP_POLL,   BASE_NS + 1600000001, 32'sh7FFF_FFFF, 32'sh8000_0000);
      // Just below the threshold ends the candidate run.
      send_item(wfhd_pkg::OP_SAMPLE, BASE_NS + 700000000, 0, 32'sd65535999);
      send_item(wfhd_pkg::OP_SAMPLE, BASE_NS + 800000000, 0, 32'sh4000_0000);
      send_item(wfhd_pkg::OP_SAMPLE, BASE_NS + 1300000000, 0, 32'sh4000_0000);
      // A poll in the past must not clear anything.
      send_item(wfhd_pkg::OP_POLL,   BASE_NS, 0, 0);
      send_item(wfhd_pkg::OP_SAMPLE, BASE_NS + 5, 0, 32'sh4000_0000);
      send_item(wfhd_pkg::OP_POLL,   BASE_NS + 5, 0, 0);
      send_item(wfhd_pkg::OP_SAMPLE, {wfhd_pkg::TIME_W{1'b1}}, 0, -32'sh4000_0000);
      send_item(wfhd_pkg::OP_POLL,   {wfhd_pkg::TIME_W{1'b1}}, 0, 0);
      send_item(wfhd_pkg::OP_SAMPLE, 0, 0, 0);
      send_item(wfhd_pkg::OP_POLL,   0, -1, -1);
   endtask

   task automatic run_random(input int count);
      logic [63:0] rnd;
      logic [63:0] span;
      logic        op;
      wfhd_pkg::time_type t;
      logic signed [wfhd_pkg::VALUE_W-1:0] pos;
      logic signed [wfhd_pkg::VALUE_W-1:0] eff;
      longint      lo;
      longint      hi;
      longint      off;
      int          k;
      for (int i = 0; i < count; i++) begin
         rnd = {$urandom, $urandom};
         op  = ($urandom_range(0, 99) < 20) ? wfhd_pkg::OP_POLL : wfhd_pkg::OP_SAMPLE;
         pos = $urandom;
         eff = $urandom;
         if (op == wfhd_pkg::OP_POLL) begin
            k = $urandom_range(0, 5);
            case (k)
               0:       t = rnd[wfhd_pkg::TIME_W-1:0];
               1, 2:    t = cur_time;
               default: t = sb.sig_end[wfhd_pkg::TIME_W-1:0] + wfhd_pkg::time_type'(k - 4);
            endcase
         end else begin
            // Mostly small forward steps against the hold time, so runs can mature.
            span = 64'(sb.hold_time) / 3 + 2;
            k = $urandom_range(0, 99);
            if (k < 3) begin
               cur_time = rnd[wfhd_pkg::TIME_W-1:0];
            end else if (k < 6) begin
               cur_time = cur_time - wfhd_pkg::time_type'(rnd % span);
            end else if (k < 8) begin
               cur_time = {wfhd_pkg::TIME_W{1'b1}} - wfhd_pkg::time_type'(rnd[15:0]);
            end else begin
               cur_time = cur_time + wfhd_pkg::time_type'(rnd % span);
            end
            t = cur_time;
            if ($urandom_range(0, 99) < 85 && sb.window_lo <= sb.window_hi) begin
               lo  = sb.window_lo;
               hi  = sb.window_hi;
               off = longint'($urandom % (hi - lo + 1));
               pos = wfhd_pkg::VALUE_W'(lo + off);
            end
            k = $urandom_range(0, 99);
            if (k < 5) begin
               eff = 32'sh8000_0000;
            end else if (k < 12) begin
               eff = wfhd_pkg::VALUE_W'(sb.min_effort) -
                     wfhd_pkg::VALUE_W'($urandom_range(0, 1));
               if ($urandom_range(0, 1)) eff = -eff;
            end else if (k < 85) begin
               span = 64'h8000_0000 - sb.min_effort;
               eff  = wfhd_pkg::VALUE_W'(sb.min_effort + $urandom % span);
               if ($urandom_range(0, 1)) eff = -eff;
            end
         end
         send_item(op, t, pos, eff);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_result(rsp_bus.grasp, rsp_bus.first_trigger);
      end
   end

   // Response stalls follow a rotating pattern, plus one long hold-off that
   // backs up the pipeline while requests keep coming.
   initial begin
      int  cyc;
      bit  held_off;
      cyc      = 0;
      held_off = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (!held_off && sb.requests_seen >= 300) begin
            held_off = 1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         case ((cyc / 64) % 4)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= $urandom_range(0, 1);
            2:       rsp_bus.ready <= (cyc % 7) > 2;
            default: rsp_bus.ready <= $urandom_range(0, 99) < 85;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      logic signed [wfhd_pkg::VALUE_W-1:0] lo_pick;
      logic signed [wfhd_pkg::VALUE_W-1:0] hi_pick;
      logic signed [wfhd_pkg::VALUE_W-1:0] swap;
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_bus.valid     = 1'b0;
      req_bus.operation = wfhd_pkg::OP_SAMPLE;
      req_bus.time_ns   = '0;
      req_bus.position  = '0;
      req_bus.effort    = '0;
      cur_time          = BASE_NS;
      burst_left        = 0;
      quiet_cycles      = 0;
      csr_writes        = 0;
      settings_used     = 1;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register defaults from reset.
      run_directed();
      run_random(PHASE_ITEMS);

      // Narrow window, short hold and stretch.
      apply_setting(-32'sd655360, 32'sd655360, 31'd327680, 40'd1000, 40'd400);
      run_random(PHASE_ITEMS);

      // Everything qualifies at once and the signal lasts zero time.
      apply_setting(32'sh8000_0000, 32'sh7FFF_FFFF, '0, '0, '0);
      run_random(PHASE_ITEMS);

      // Largest threshold and longest durations.
      lo_pick = $urandom;
      hi_pick = $urandom;
      if (lo_pick > hi_pick) begin
         swap    = lo_pick;
         lo_pick = hi_pick;
         hi_pick = swap;
      end
      apply_setting(lo_pick, hi_pick, {wfhd_pkg::THRESH_W{1'b1}}, {wfhd_pkg::DUR_W{1'b1}},
                    {wfhd_pkg::DUR_W{1'b1}});
      run_random(PHASE_ITEMS);

      // Inverted window never matches.
      apply_setting(32'sd100, -32'sd100, wfhd_pkg::THRESH_W'($urandom), 40'd50, 40'd30);
      run_random(PHASE_ITEMS);

      // Single-point window with random durations.
      lo_pick = $urandom;
      apply_setting(lo_pick, lo_pick, wfhd_pkg::THRESH_W'($urandom),
                    wfhd_pkg::DUR_W'($urandom_range(0, 5000)),
                    wfhd_pkg::DUR_W'({$urandom, $urandom}));
      run_random(PHASE_ITEMS);

      drain();
      if (sb.pending_grasps.size() != 0) begin
         sb.report_mismatch($sformatf("%0d predicted results never arrived",
                                      sb.pending_grasps.size()));
      end
      $display("Run covered %0d requests (%0d polls) over %0d register settings, %0d writes.",
               sb.requests_seen, sb.polls, settings_used, csr_writes);
      $display("Checked %0d results: %0d detections, %0d time rewinds, %0d mismatches.",
               sb.results_checked, sb.detections, sb.rewinds, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
